/* hw/rtl/rnes_pkg.sv */
`default_nettype none
package rnes_pkg;

    // Fixed sizes of the network and the item fields
    localparam int NSPEC   = 6;
    localparam int NREACT  = 5;
    localparam int NMICRO  = 8;
    localparam int AMT_W   = 32;
    localparam int RATE_W  = 17;
    localparam int THR_W   = 16;
    localparam int PCNT_W  = 3;
    localparam int STEP_W  = 20;
    localparam int PIDX_W  = 5;   // holds a pulse count up to thirty-one
    localparam int CFG_W   = 17;
    localparam int CIDX_W  = 3;

    // Operation codes
    typedef logic [1:0] t_op;
    localparam t_op OP_LOAD_SPECIES = 2'd0;
    localparam t_op OP_LOAD_PULSE   = 2'd1;
    localparam t_op OP_ADVANCE      = 2'd2;

    // Configuration register indexes
    localparam logic [CIDX_W-1:0] CFG_RATE_LAST  = 3'd4;
    localparam logic [CIDX_W-1:0] CFG_THRESHOLD  = 3'd5;
    localparam logic [CIDX_W-1:0] CFG_PULSE_CNT  = 3'd6;

    // Species indexes
    localparam logic [2:0] SP_L = 3'd0;
    localparam logic [2:0] SP_R = 3'd1;
    localparam logic [2:0] SP_B = 3'd2;
    localparam logic [2:0] SP_D = 3'd3;
    localparam logic [2:0] SP_C = 3'd4;
    localparam logic [2:0] SP_X = 3'd5;

    typedef enum logic [1:0] {
        ST_RUNNING = 2'd0,
        ST_EQUIL   = 2'd1,
        ST_LIMIT   = 2'd2
    } t_status;

    typedef struct packed {
        logic [1:0]         operation;
        logic [2:0]         species_index;
        logic signed [31:0] species_value;
        logic [1:0]         pulse_slot;
        logic [2:0]         pulse_species;
        logic [19:0]        pulse_start;
        logic [19:0]        pulse_end;
        logic signed [31:0] pulse_amount;
    } t_in;

    typedef struct packed {
        logic signed [31:0] amount_l;
        logic signed [31:0] amount_r;
        logic signed [31:0] amount_b;
        logic signed [31:0] amount_d;
        logic signed [31:0] amount_c;
        logic signed [31:0] amount_x;
        logic [19:0]        step_index;
        logic [1:0]         status;
    } t_out;

    // Stoichiometry sign per reaction and species
    typedef logic signed [1:0] t_sgn;
    localparam t_sgn STOICH [0:NREACT-1][0:NSPEC-1] = '{
        '{-2'sd1, -2'sd1,  2'sd1,  2'sd0,  2'sd0, 2'sd0},
        '{ 2'sd1,  2'sd1, -2'sd1,  2'sd0,  2'sd0, 2'sd0},
        '{-2'sd1,  2'sd0,  2'sd0, -2'sd1,  2'sd1, 2'sd0},
        '{ 2'sd1,  2'sd0,  2'sd0,  2'sd1, -2'sd1, 2'sd0},
        '{-2'sd1,  2'sd0,  2'sd0,  2'sd0,  2'sd0, 2'sd0}
    };

    // One multiply of the tick sequence
    typedef struct packed {
        logic       use_ext;  // multiplicand is the partial extent, not the rate
        logic [2:0] react;
        logic [2:0] spec;
        logic       last;     // extent complete, apply to amounts
    } t_micro;

    localparam t_micro MICRO [0:NMICRO-1] = '{
        '{1'b0, 3'd0, SP_L, 1'b0},
        '{1'b1, 3'd0, SP_R, 1'b1},
        '{1'b0, 3'd1, SP_B, 1'b1},
        '{1'b0, 3'd2, SP_L, 1'b0},
        '{1'b1, 3'd2, SP_D, 1'b1},
        '{1'b0, 3'd3, SP_C, 1'b1},
        '{1'b0, 3'd4, SP_L, 1'b0},
        '{1'b1, 3'd4, SP_X, 1'b1}
    };

    // Controller to datapath commands
    typedef struct packed {
        logic              load;
        logic              snap;
        logic              mul;
        logic              acc;
        logic [2:0]        micro;
        logic              pulse;
        logic [PIDX_W-1:0] pidx;
        logic              settle;
        logic              capture;
    } t_cmd;

    // Datapath to controller status
    typedef struct packed {
        logic              running;
        logic [PIDX_W-1:0] pulse_n;
    } t_sts;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL,
        S_ACC,
        S_PULSE,
        S_SETTLE,
        S_RESP
    } t_state;

    // Saturate to signed 32 bits
    function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
        logic signed [31:0] r;
        if (v > 64'sh7FFFFFFF) begin
            r = 32'sh7FFFFFFF;
        end else if (v < -64'sh80000000) begin
            r = 32'sh80000000;
        end else begin
            r = v[31:0];
        end
        return r;
    endfunction

endpackage
`default_nettype wire

/* hw/rtl/rnes_ctrl.sv */
`default_nettype none
module rnes_ctrl
    import rnes_pkg::*;
(
    input  wire logic i_clk,
    input  wire logic i_rst_n,
    input  wire logic i_in_valid,
    output logic      o_in_ready,
    input  wire t_op  i_op,
    output logic      o_out_valid,
    input  wire logic i_out_ready,
    input  wire t_sts i_sts,
    output t_cmd      o_cmd
);

    t_state            r_state, n_state;
    logic [2:0]        r_micro;
    logic [PIDX_W-1:0] r_pidx;
    logic              r_out_valid;
    logic              in_xfer;
    logic              out_free;

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_xfer     = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_xfer) begin
                    if (i_op == OP_ADVANCE && i_sts.running) n_state = S_MUL;
                    else n_state = S_RESP;
                end
            end
            S_MUL:    n_state = S_ACC;
            S_ACC: begin
                if (r_micro == 3'(NMICRO - 1)) n_state = S_PULSE;
                else n_state = S_MUL;
            end
            S_PULSE: begin
                if (r_pidx >= i_sts.pulse_n) n_state = S_SETTLE;
            end
            S_SETTLE: n_state = S_RESP;
            S_RESP: begin
                if (out_free) n_state = S_IDLE;
            end
            default:  n_state = S_IDLE;
        endcase
    end

    // Commands
    always_comb begin
        o_cmd         = '0;
        o_cmd.micro   = r_micro;
        o_cmd.pidx    = r_pidx;
        o_cmd.load    = in_xfer;
        o_cmd.snap    = in_xfer && i_op == OP_ADVANCE;
        unique case (r_state)
            S_MUL:    o_cmd.mul = 1'b1;
            S_ACC:    o_cmd.acc = 1'b1;
            S_PULSE:  o_cmd.pulse = (r_pidx < i_sts.pulse_n);
            S_SETTLE: o_cmd.settle = 1'b1;
            S_RESP:   o_cmd.capture = out_free;
            default:  o_cmd.settle = 1'b0;
        endcase
    end

    // State and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_micro     <= '0;
            r_pidx      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (in_xfer) r_micro <= '0;
            else if (o_cmd.acc) r_micro <= r_micro + 3'd1;
            if (in_xfer) r_pidx <= '0;
            else if (o_cmd.pulse) r_pidx <= r_pidx + PIDX_W'(1);
            if (o_cmd.capture) r_out_valid <= 1'b1;
            else if (i_out_ready) r_out_valid <= 1'b0;
        end
    end

    a_accept_leaves_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_xfer |=> r_state != S_IDLE) else $error("accept did not start work");
    a_mul_then_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_MUL |=> r_state == S_ACC) else $error("multiply not followed by accumulate");
    a_pidx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == S_PULSE |-> r_pidx <= i_sts.pulse_n) else $error("pulse index overran");

endmodule
`default_nettype wire

/* hw/rtl/rnes_datapath.sv */
`default_nettype none
module rnes_datapath
    import rnes_pkg::*;
#(
    parameter int MAX_PULSES = 4,
    parameter int MAX_STEPS  = 1048576,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data,
    input  wire t_in               i_in,
    input  wire t_cmd              i_cmd,
    output t_sts                   o_sts,
    output t_out                   o_out
);

    localparam int PW = (MAX_PULSES > 1) ? $clog2(MAX_PULSES) : 1;
    localparam logic [STEP_W:0] LAST_STEP = (STEP_W+1)'(MAX_STEPS - 1);
    localparam logic signed [63:0] HALF = 64'sd1 <<< (FRAC_BITS - 1);

    logic [RATE_W-1:0]        r_rate [NREACT];
    logic [THR_W-1:0]         r_thr;
    logic [PCNT_W-1:0]        r_pcnt;
    logic signed [AMT_W-1:0]  r_amt  [NSPEC];
    logic signed [AMT_W-1:0]  r_prev [NSPEC];
    logic [STEP_W-1:0]        r_step;
    t_status                  r_status;
    logic signed [63:0]       r_prod;
    logic signed [AMT_W-1:0]  r_ext;
    logic [2:0]               r_ptgt [MAX_PULSES];
    logic [STEP_W-1:0]        r_pfrom [MAX_PULSES];
    logic [STEP_W-1:0]        r_puntil [MAX_PULSES];
    logic signed [AMT_W-1:0]  r_pdelta [MAX_PULSES];
    t_out                     r_out;

    t_micro                   mic;
    logic signed [AMT_W-1:0]  op_a, op_b, ext;
    logic signed [63:0]       rounded;
    logic [STEP_W:0]          next_step;
    logic [PW-1:0]            pe;
    logic [2:0]               ptgt;
    logic                     pact;
    logic signed [AMT_W-1:0]  psum;
    logic                     settled;
    logic signed [AMT_W:0]    diff;
    logic [AMT_W:0]           mag;

    // Status toward controller
    always_comb begin
        o_sts.running = (r_status == ST_RUNNING);
        if (int'(r_pcnt) > MAX_PULSES) o_sts.pulse_n = PIDX_W'(MAX_PULSES);
        else o_sts.pulse_n = PIDX_W'(r_pcnt);
    end

    // Multiply operands and rounding of the registered product
    always_comb begin
        mic     = MICRO[i_cmd.micro];
        op_a    = mic.use_ext ? r_ext : $signed({{(AMT_W-RATE_W){1'b0}}, r_rate[mic.react]});
        op_b    = r_prev[mic.spec];
        rounded = (r_prod + HALF) >>> FRAC_BITS;
        ext     = sat32(rounded);
    end

    // Pulse entry and change check
    always_comb begin
        next_step = {1'b0, r_step} + (STEP_W+1)'(1);
        pe        = i_cmd.pidx[PW-1:0];
        ptgt      = r_ptgt[pe];
        pact      = (ptgt < 3'(NSPEC)) && next_step >= {1'b0, r_pfrom[pe]}
                    && next_step < {1'b0, r_puntil[pe]};
        psum      = sat32(64'(r_amt[ptgt < 3'(NSPEC) ? ptgt : SP_L]) + 64'(r_pdelta[pe]));
        settled   = 1'b1;
        diff      = '0;
        mag       = '0;
        for (int c = 0; c < NSPEC; c++) begin
            diff = (AMT_W+1)'(r_amt[c]) - (AMT_W+1)'(r_prev[c]);
            mag  = diff[AMT_W] ? unsigned'(-diff) : unsigned'(diff);
            if (!(mag < (AMT_W+1)'(r_thr))) settled = 1'b0;
        end
    end

    // Control state: configuration, step and status
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int r = 0; r < NREACT; r++) r_rate[r] <= '0;
            r_thr    <= THR_W'(1);
            r_pcnt   <= '0;
            r_step   <= '0;
            r_status <= ST_RUNNING;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_idx <= CFG_RATE_LAST) r_rate[i_cfg_idx] <= i_cfg_data;
                else if (i_cfg_idx == CFG_THRESHOLD) r_thr <= i_cfg_data[THR_W-1:0];
                else if (i_cfg_idx == CFG_PULSE_CNT) r_pcnt <= i_cfg_data[PCNT_W-1:0];
            end
            if (i_cmd.load && ((i_in.operation == OP_LOAD_SPECIES
                    && i_in.species_index < 3'(NSPEC))
                || (i_in.operation == OP_LOAD_PULSE && int'(i_in.pulse_slot) < MAX_PULSES)))
            begin
                r_step   <= '0;
                r_status <= ST_RUNNING;
            end
            if (i_cmd.settle) begin
                r_step <= next_step[STEP_W-1:0];
                if (settled) r_status <= ST_EQUIL;
                else if (next_step >= LAST_STEP) r_status <= ST_LIMIT;
            end
        end
    end

    // Amounts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int c = 0; c < NSPEC; c++) r_amt[c] <= '0;
        end else begin
            if (i_cmd.load && i_in.operation == OP_LOAD_SPECIES
                    && i_in.species_index < 3'(NSPEC)) begin
                r_amt[i_in.species_index] <= i_in.species_value;
            end
            if (i_cmd.acc && mic.last) begin
                for (int c = 0; c < NSPEC; c++) begin
                    if (STOICH[mic.react][c] == 2'sd1)
                        r_amt[c] <= sat32(64'(r_amt[c]) + 64'(ext));
                    else if (STOICH[mic.react][c] == -2'sd1)
                        r_amt[c] <= sat32(64'(r_amt[c]) - 64'(ext));
                end
            end
            if (i_cmd.pulse && pact) begin
                r_amt[ptgt] <= psum[AMT_W-1] ? '0 : psum;
            end
        end
    end

    // Datapath registers: snapshot, product, partial extent, pulse table, result
    always_ff @(posedge i_clk) begin
        if (i_cmd.snap) begin
            for (int c = 0; c < NSPEC; c++) r_prev[c] <= r_amt[c];
        end
        if (i_cmd.mul) r_prod <= 64'(op_a) * 64'(op_b);
        if (i_cmd.acc && !mic.last) r_ext <= ext;
        if (i_cmd.load && i_in.operation == OP_LOAD_PULSE) begin
            for (int k = 0; k < MAX_PULSES; k++) begin
                if (k == int'(i_in.pulse_slot)) begin
                    r_ptgt[k]   <= i_in.pulse_species;
                    r_pfrom[k]  <= i_in.pulse_start;
                    r_puntil[k] <= i_in.pulse_end;
                    r_pdelta[k] <= i_in.pulse_amount;
                end
            end
        end
        if (i_cmd.capture) begin
            r_out.amount_l   <= r_amt[SP_L];
            r_out.amount_r   <= r_amt[SP_R];
            r_out.amount_b   <= r_amt[SP_B];
            r_out.amount_d   <= r_amt[SP_D];
            r_out.amount_c   <= r_amt[SP_C];
            r_out.amount_x   <= r_amt[SP_X];
            r_out.step_index <= r_step;
            r_out.status     <= r_status;
        end
    end

    assign o_out = r_out;

    a_step_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, r_step} <= LAST_STEP) else $error("step counter past limit");
    a_stop_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_status != ST_RUNNING && !i_cmd.load) |=> $stable(r_step))
        else $error("stopped run advanced");
    a_settle_running: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.settle |-> r_status == ST_RUNNING) else $error("tick while stopped");

endmodule
`default_nettype wire

/* hw/rtl/reaction_network_euler_step.sv */
`default_nettype none
// Channel   Direction  Handshake                  Payload
// in        input      i_in_valid / o_in_ready    i_in  (t_in)
// out       output     o_out_valid / i_out_ready  o_out (t_out)
// cfg       input      i_cfg_we                   i_cfg_idx, i_cfg_data
//
// Load items and advances on a stopped run go from accept to the result state;
// a running advance takes the eight products on the shared multiplier (each a
// multiply, then an accumulate), the pulse entries in use, a settle and a result.
// One item is in work at a time; the result register frees the input side.
// Reset (i_rst_n low, synchronous) clears amounts, step and status and
// returns the configuration registers to their defaults.
// A stalled output holds the result; a following item waits in the result state.
module reaction_network_euler_step
    import rnes_pkg::*;
#(
    parameter int MAX_PULSES = 4,
    parameter int MAX_STEPS  = 1048576,
    parameter int FRAC_BITS  = 16
) (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire logic              i_in_valid,
    output logic                   o_in_ready,
    input  wire t_in               i_in,
    output logic                   o_out_valid,
    input  wire logic              i_out_ready,
    output t_out                   o_out,
    input  wire logic              i_cfg_we,
    input  wire logic [CIDX_W-1:0] i_cfg_idx,
    input  wire logic [CFG_W-1:0]  i_cfg_data
);

    t_cmd cmd;
    t_sts sts;

    rnes_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_op        (i_in.operation),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rnes_datapath #(
        .MAX_PULSES (MAX_PULSES),
        .MAX_STEPS  (MAX_STEPS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_in       (i_in),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_out      (o_out)
    );

endmodule
`default_nettype wire
